### rtl/core/iegd_pkg.sv
// ----------------------------------------------------------------------------
// iegd_pkg: shared types and constants of the exp-Golomb decoder
// Field widths, code limits, register indexes and the structs that pass
// between the input queue and the bit-serial decode engine.
// ----------------------------------------------------------------------------
package iegd_pkg;

  // Longest accepted prefix; a longer one ends the code as an error.
  localparam int unsigned MaxPrefix  = 16;
  localparam int unsigned PcW        = $clog2(MaxPrefix + 1);
  localparam int unsigned ValueW     = 18;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned BitIdxW    = $clog2(ByteW);
  // Bound on guard bits fed after the final byte.
  localparam int unsigned GuardSteps = 2 * MaxPrefix + 8;
  localparam int unsigned StepW      = $clog2(GuardSteps + 1);
  localparam int unsigned OutDataW   = ((ValueW + 7) / 8) * 8;
  localparam int unsigned OutUserW   = 3;

  // Configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 1;
  localparam logic [CfgIdxW-1:0] CfgSignedMode = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgGuardFill  = 1'd1;

  typedef struct packed {
    logic signed_mode;
    logic guard_fill;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] stream_byte;
    logic             is_last;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              has_value;
    logic              overrun;
    logic              code_error;
    logic              stream_end;
  } result_t;

endpackage

### rtl/core/iegd_front.sv
// ----------------------------------------------------------------------------
// iegd_front: input queue of the exp-Golomb decoder
// Two-entry queue of stream bytes that decouples the input channel from the
// decode engine.
// ----------------------------------------------------------------------------
module iegd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  iegd_pkg::item_t in_item_i,
  output iegd_pkg::head_t head_o,
  input  logic            pop_i
);
  import iegd_pkg::*;

  item_t      entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign in_ready_o = (count_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (count_q != 2'd0);

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.item  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

### rtl/core/iegd_back.sv
// ----------------------------------------------------------------------------
// iegd_back: bit-serial decode engine of the exp-Golomb decoder
// Consumes the queue head one bit per cycle while the result register is free,
// feeds guard bits after the final byte and drives the registered result channel.
// ----------------------------------------------------------------------------
module iegd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  iegd_pkg::cfg_t    cfg_i,
  input  iegd_pkg::head_t   head_i,
  output logic              pop_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output iegd_pkg::result_t res_o
);
  import iegd_pkg::*;

  localparam logic [1:0] PhPrefix = 2'd0;
  localparam logic [1:0] PhData   = 2'd1;
  localparam logic [1:0] PhSign   = 2'd2;

  logic [1:0]         phase_q, phase_d;
  logic [PcW-1:0]     pc_q, pc_d;
  logic [ValueW-1:0]  info_q, info_d;
  logic [BitIdxW-1:0] bit_idx_q, bit_idx_d;
  logic               guard_q, guard_d;
  logic [StepW-1:0]   steps_q, steps_d;
  logic               hold_v_q, hold_v_d;
  result_t            hold_q, hold_d;
  logic               out_v_q, out_v_d;
  result_t            out_q, out_d;

  logic               out_free, advance, guard_done, cur_bit;
  logic [ValueW-1:0]  mag;
  logic [1:0]         f_phase;
  logic [PcW-1:0]     f_pc;
  logic [ValueW-1:0]  f_info;
  logic               f_valid;
  result_t            f_res;
  logic               emit_v;
  result_t            emit;

  assign out_free   = !out_v_q || res_ready_i;
  assign advance    = head_i.valid && out_free;
  assign guard_done = ((phase_q == PhPrefix) && (pc_q == '0)) ||
                      (steps_q == StepW'(GuardSteps));
  assign cur_bit    = guard_q ? cfg_i.guard_fill : head_i.item.stream_byte[bit_idx_q];
  assign mag        = ((ValueW'(1) << pc_q) - ValueW'(1)) + info_q;

  // One bit of code: next code state and the result it may finish.
  always_comb begin
    f_phase            = phase_q;
    f_pc               = pc_q;
    f_info             = info_q;
    f_valid            = 1'b0;
    f_res              = '0;
    f_res.overrun      = guard_q;
    unique case (phase_q)
      PhData: begin
        f_info  = {info_q[ValueW-2:0], cur_bit};
        f_phase = PhPrefix;
      end
      PhSign: begin
        f_valid         = 1'b1;
        f_res.value     = cur_bit ? (ValueW'(0) - mag) : mag;
        f_res.has_value = 1'b1;
      end
      default: begin
        if (cur_bit) begin
          if (cfg_i.signed_mode && (mag != '0)) begin
            f_phase = PhSign;
          end else begin
            f_valid         = 1'b1;
            f_res.value     = mag;
            f_res.has_value = 1'b1;
          end
        end else if (pc_q >= PcW'(MaxPrefix)) begin
          f_valid          = 1'b1;
          f_res.code_error = 1'b1;
        end else begin
          f_pc    = pc_q + PcW'(1);
          f_phase = PhData;
        end
      end
    endcase
    // A finished code leaves the state clear.
    if (f_valid) begin
      f_phase = PhPrefix;
      f_pc    = '0;
      f_info  = '0;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    pc_d      = pc_q;
    info_d    = info_q;
    bit_idx_d = bit_idx_q;
    guard_d   = guard_q;
    steps_d   = steps_q;
    hold_v_d  = hold_v_q;
    hold_d    = hold_q;
    pop_o     = 1'b0;
    emit_v    = 1'b0;
    emit      = f_res;
    if (advance) begin
      if (guard_q && guard_done) begin
        // Close the stream: flag the held result, or send an empty end marker.
        emit_v = 1'b1;
        if (hold_v_q) begin
          emit = hold_q;
        end else begin
          emit = '0;
        end
        emit.stream_end = 1'b1;
        hold_v_d  = 1'b0;
        phase_d   = PhPrefix;
        pc_d      = '0;
        info_d    = '0;
        guard_d   = 1'b0;
        steps_d   = '0;
        bit_idx_d = BitIdxW'(ByteW - 1);
        pop_o     = 1'b1;
      end else begin
        phase_d = f_phase;
        pc_d    = f_pc;
        info_d  = f_info;
        if (f_valid) begin
          if (head_i.item.is_last) begin
            // Delay one result so the last of the stream can be flagged.
            emit_v   = hold_v_q;
            emit     = hold_q;
            hold_d   = f_res;
            hold_v_d = 1'b1;
          end else begin
            emit_v = 1'b1;
          end
        end
        if (guard_q) begin
          steps_d = steps_q + StepW'(1);
        end else if (bit_idx_q == '0) begin
          bit_idx_d = BitIdxW'(ByteW - 1);
          if (head_i.item.is_last) begin
            guard_d = 1'b1;
            steps_d = '0;
          end else begin
            pop_o = 1'b1;
          end
        end else begin
          bit_idx_d = bit_idx_q - BitIdxW'(1);
        end
      end
    end
  end

  always_comb begin
    out_v_d = out_v_q;
    out_d   = out_q;
    if (out_free) begin
      out_v_d = emit_v;
      out_d   = emit;
    end
  end

  assign res_valid_o = out_v_q;
  assign res_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhPrefix;
      pc_q      <= '0;
      info_q    <= '0;
      bit_idx_q <= BitIdxW'(ByteW - 1);
      guard_q   <= 1'b0;
      steps_q   <= '0;
      hold_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      pc_q      <= pc_d;
      info_q    <= info_d;
      bit_idx_q <= bit_idx_d;
      guard_q   <= guard_d;
      steps_q   <= steps_d;
      hold_v_q  <= hold_v_d;
      out_v_q   <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    out_q  <= out_d;
  end

endmodule

### rtl/core/interleaved_exp_golomb_decoder.sv
// ----------------------------------------------------------------------------
// interleaved_exp_golomb_decoder: stream decoder for interleaved exp-Golomb
// Takes coded bytes MSB first and returns one result per finished code.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_axis_*: one stream byte per transaction in tdata, with
//   tlast marking the final byte of a stream. Output channel m_axis_*: one
//   result per transaction; tdata holds the value (signed in signed mode),
//   tuser the flags, tlast marks the last result caused by the final byte.
//   Configuration: write signed_mode (index 0) or guard_fill (index 1)
//   through cfg_we_i / cfg_idx_i / cfg_wdata_i while the block is idle.
// Throughput: the decode engine consumes one bit per cycle while the output
//   register is free. After the final byte it feeds the guard bits needed
//   to finish a pending code, then closes the stream.
// Output: a result is on m_axis right after the edge that consumes its
//   last bit; results of a final byte are held until the next result or the
//   stream close, so the last of them can carry tlast.
// Reset: both config registers return to 1, the queue empties and any
//   partial code is dropped.
// Stall: the output register holds a result until it is taken; the engine
//   stops while it is full, and the two-entry queue keeps accepting bytes
//   until it fills.
// ----------------------------------------------------------------------------
module interleaved_exp_golomb_decoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Slave stream: tdata = stream_byte[7:0]; tlast = is_last
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [iegd_pkg::ByteW-1:0]        s_axis_tdata,
  input  logic                              s_axis_tlast,
  // Master stream: tdata = value[17:0], zero fill to 24 bits
  //                tuser = has_value[0], overrun[1], code_error[2]
  //                tlast = stream_end
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [iegd_pkg::OutDataW-1:0]     m_axis_tdata,
  output logic [iegd_pkg::OutUserW-1:0]     m_axis_tuser,
  output logic                              m_axis_tlast,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [iegd_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [iegd_pkg::CfgDataW-1:0]     cfg_wdata_i
);
  import iegd_pkg::*;

  cfg_t    cfg_q, cfg_d;
  item_t   in_item;
  head_t   head;
  logic    pop;
  result_t res;

  // Config registers: take a write on any edge with the enable high.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSignedMode: cfg_d.signed_mode = cfg_wdata_i[0];
        CfgGuardFill:  cfg_d.guard_fill  = cfg_wdata_i[0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.signed_mode <= 1'b1;
      cfg_q.guard_fill  <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_item.stream_byte = s_axis_tdata;
  assign in_item.is_last     = s_axis_tlast;

  // Front: queue incoming bytes.
  iegd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .head_o     (head),
    .pop_i      (pop)
  );

  // Back: decode bits and drive the result register.
  iegd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head),
    .pop_o       (pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // Pack the result fields onto the master stream.
  assign m_axis_tdata = {(OutDataW - ValueW)'(0), res.value};
  assign m_axis_tuser = {res.code_error, res.overrun, res.has_value};
  assign m_axis_tlast = res.stream_end;

endmodule

### rtl/core/iegd_checker.sv
// ----------------------------------------------------------------------------
// iegd_port_checker: port-level checks of the exp-Golomb decoder
// Watches the top-level ports and flags malformed result transactions.
// ----------------------------------------------------------------------------
module iegd_port_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [iegd_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [iegd_pkg::OutUserW-1:0] m_axis_tuser,
  input logic                          m_axis_tlast
);
  import iegd_pkg::*;

  // Hold a stalled result unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled result changed");

  // A result without a value carries a zero value.
  a_no_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata == '0))
    else $error("value nonzero without has_value");

  // An error result never carries a value.
  a_error_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |-> !m_axis_tuser[0])
    else $error("code_error together with has_value");

  // A flagless result is only the empty end marker.
  a_empty_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] && !m_axis_tuser[2] |->
      m_axis_tlast && !m_axis_tuser[1])
    else $error("empty result outside stream end");

endmodule

bind interleaved_exp_golomb_decoder iegd_port_checker u_iegd_checker (.*);
